[hw/rtl/xon_xoff_receive_fifo_assert.svh]
// Assertion macros used by the receive FIFO core module.
// Define NO_ASSERTIONS to compile them away.
`ifndef XON_XOFF_RECEIVE_FIFO_ASSERT_SVH
`define XON_XOFF_RECEIVE_FIFO_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked on every rising edge, switched off while rst is high.
`define XXRF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// Checked on every rising edge, including the reset cycles.
`define XXRF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) \
      else $error(msg);

`else

`define XXRF_ASSERT(label, clk, rst, prop, msg)
`define XXRF_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

[hw/rtl/xxrf_pkg.sv]
`timescale 1ns / 1ps

package xxrf_pkg;

   // Buffer geometry.
   localparam int DEPTH   = 8;
   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int LEVEL_W = 4;
   localparam int XON_W   = 4;
   localparam int CMP_W   = (CNT_W > XON_W) ? CNT_W : XON_W;
   localparam int BYTE_W  = 8;

   // Configuration register map.
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_XON_LEVEL = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENDFILE   = 1'b1;

   localparam logic [XON_W-1:0]  XON_LEVEL_RESET = 4'd6;
   localparam logic [BYTE_W-1:0] ENDFILE_RESET   = 8'd26;

   // Request opcodes.
   localparam logic OP_RECEIVE = 1'b0;
   localparam logic OP_CONSUME = 1'b1;

   // Flow control characters.
   localparam logic [1:0] CTRL_XOFF = 2'd0;
   localparam logic [1:0] CTRL_XON  = 2'd1;
   localparam logic [1:0] CTRL_ACK  = 2'd2;

   typedef struct packed {
      logic              opcode;
      logic [BYTE_W-1:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic               out_valid;
      logic [BYTE_W-1:0]  out_byte;
      logic               ctrl_valid;
      logic [1:0]         ctrl_code;
      logic               dropped;
      logic               finished;
      logic [LEVEL_W-1:0] level;
   } rsp_type;

   // Ring pointer advance with wrap at DEPTH.
   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      logic [PTR_W-1:0] res;
      if (ptr == PTR_W'(DEPTH - 1)) begin
         res = '0;
      end else begin
         res = ptr + PTR_W'(1);
      end
      return res;
   endfunction

   // True when the fill count has dropped below the XON threshold.
   function automatic logic below_xon(input logic [CNT_W-1:0] cnt,
                                      input logic [XON_W-1:0] lvl);
      return CMP_W'(cnt) < CMP_W'(lvl);
   endfunction

endpackage

[hw/rtl/xon_xoff_receive_fifo.sv]
`timescale 1ns / 1ps

// Receive FIFO with XON/XOFF flow control. Each request either hands in one
// byte from the link (opcode receive) or asks to consume one byte (opcode
// consume), and every request yields exactly one result carrying the popped
// byte if any, a control character to send back (XOFF when a push fills the
// buffer, XON when a pop brings the fill count below xon_level, ACK on the
// end-of-file code), a drop flag, the finished flag and the fill count. The
// block takes one request per clock cycle and keeps that rate for as long as
// the result side keeps up. A request is first held in the input register,
// its result is then computed and loaded into the result register, which
// drives the rsp_ port; a stalled consumer holds both registers. All
// pointer, count and flag updates are computed between the two registers
// and take effect as the result is loaded into the result register. The
// configuration registers are written through the csr_ port, which is
// always ready, and should only be changed while no request is in flight.
module xon_xoff_receive_fifo (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  xxrf_pkg::req_type                 req_data,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output xxrf_pkg::rsp_type                 rsp_data,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [xxrf_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [xxrf_pkg::BYTE_W-1:0]       csr_data
);
   import xxrf_pkg::*;

   logic [XON_W-1:0]  xon_level_ff, xon_level_in;
   logic [BYTE_W-1:0] endfile_ff,   endfile_in;

   logic    advance;
   logic    item_valid;
   req_type item;
   rsp_type result;

   // Configuration registers. Writes are accepted in every cycle.
   assign csr_ready = 1'b1;

   always_comb begin
      xon_level_in = xon_level_ff;
      endfile_in   = endfile_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_XON_LEVEL: xon_level_in = XON_W'(csr_data);
            CSR_ENDFILE:   endfile_in   = csr_data;
            default: begin
               xon_level_in = xon_level_ff;
               endfile_in   = endfile_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         xon_level_ff <= XON_LEVEL_RESET;
         endfile_ff   <= ENDFILE_RESET;
      end else begin
         xon_level_ff <= xon_level_in;
         endfile_ff   <= endfile_in;
      end
   end

   // Input register: holds the request that is processed next.
   xxrf_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   // Buffer state and the per-request update. The state changes only when
   // the result register can take the result, so a stalled consumer freezes
   // the buffer along with the pipeline.
   xxrf_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (item_valid && advance),
      .item         (item),
      .xon_level    (xon_level_ff),
      .endfile_code (endfile_ff),
      .result       (result)
   );

   // Result register: decouples the consumer from the buffer update.
   xxrf_out_stage u_out_stage (
      .clock        (clock),
      .reset        (reset),
      .result_valid (item_valid),
      .result       (result),
      .advance      (advance),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule

[hw/rtl/xxrf_in_stage.sv]
`timescale 1ns / 1ps

module xxrf_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  xxrf_pkg::req_type req_data,
   input  logic             advance,
   output logic             item_valid,
   output xxrf_pkg::req_type item
);
   import xxrf_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type item_ff;

   // The register can take a new request when it is empty or is handing
   // its request on in this cycle.
   assign req_ready = !valid_ff || advance;
   assign valid_in  = req_ready ? req_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

[hw/rtl/xxrf_core.sv]
`timescale 1ns / 1ps
`include "xon_xoff_receive_fifo_assert.svh"

module xxrf_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  xxrf_pkg::req_type               item,
   input  logic [xxrf_pkg::XON_W-1:0]      xon_level,
   input  logic [xxrf_pkg::BYTE_W-1:0]     endfile_code,
   output xxrf_pkg::rsp_type               result
);
   import xxrf_pkg::*;

   logic [BYTE_W-1:0] store_ff [DEPTH];

   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic             xoff_ff,   xoff_in;
   logic             end_ff,    end_in;
   logic             push;
   rsp_type          res;

   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      cnt_in    = cnt_ff;
      xoff_in   = xoff_ff;
      end_in    = end_ff;
      push      = 1'b0;
      res       = '0;

      if (item.opcode == OP_RECEIVE) begin
         if (!end_ff) begin
            if (item.rx_byte == endfile_code) begin
               end_in         = 1'b1;
               res.ctrl_valid = 1'b1;
               res.ctrl_code  = CTRL_ACK;
            end else if (cnt_ff == CNT_W'(DEPTH)) begin
               res.dropped = 1'b1;
            end else begin
               push      = 1'b1;
               wr_ptr_in = next_ptr(wr_ptr_ff);
               cnt_in    = cnt_ff + CNT_W'(1);
               if (cnt_in == CNT_W'(DEPTH) && !xoff_ff) begin
                  xoff_in        = 1'b1;
                  res.ctrl_valid = 1'b1;
                  res.ctrl_code  = CTRL_XOFF;
               end
            end
         end
      end else begin
         if (cnt_ff != '0) begin
            res.out_valid = 1'b1;
            res.out_byte  = store_ff[rd_ptr_ff];
            rd_ptr_in     = next_ptr(rd_ptr_ff);
            cnt_in        = cnt_ff - CNT_W'(1);
            if (below_xon(cnt_in, xon_level) && xoff_ff) begin
               xoff_in        = 1'b0;
               res.ctrl_valid = 1'b1;
               res.ctrl_code  = CTRL_XON;
            end
         end
      end

      res.finished = end_in && (cnt_in == '0);
      res.level    = LEVEL_W'(cnt_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         cnt_ff    <= '0;
         xoff_ff   <= 1'b0;
         end_ff    <= 1'b0;
      end else if (fire) begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         cnt_ff    <= cnt_in;
         xoff_ff   <= xoff_in;
         end_ff    <= end_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && push) begin
         store_ff[wr_ptr_ff] <= item.rx_byte;
      end
   end

   assign result = res;

   `XXRF_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (cnt_ff == '0 && !end_ff && !xoff_ff), "reset did not clear the buffer state")
   `XXRF_ASSERT(a_count_bound, clock, reset, cnt_ff <= CNT_W'(DEPTH), "fill count beyond buffer depth")
   `XXRF_ASSERT(a_drop_only_full, clock, reset, (fire && res.dropped) |-> (cnt_ff == CNT_W'(DEPTH)), "byte dropped with room left")
   `XXRF_ASSERT(a_xoff_held, clock, reset, (fire && res.ctrl_valid && res.ctrl_code == CTRL_XOFF) |=> xoff_ff, "XOFF sent but not remembered")
   `XXRF_ASSERT(a_end_sticky, clock, reset, !$past(reset) |-> !$fell(end_ff), "end flag cleared without reset")

endmodule

[hw/rtl/xxrf_out_stage.sv]
`timescale 1ns / 1ps

module xxrf_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              result_valid,
   input  xxrf_pkg::rsp_type result,
   output logic              advance,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output xxrf_pkg::rsp_type rsp_data
);
   import xxrf_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   // The result register moves on when it is empty or being read.
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? result_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result_valid) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule
